### design/cbt_pkg.sv
// Shared types, constants and helper function of the closed-loop B-spline tessellator.
// Used by the controller, the datapath, the blend lanes and the top level.
`default_nettype none

package cbt_pkg;

  // Four knots blend into one point, and each point has three coordinates.
  localparam int unsigned TAPS = 4;
  localparam int unsigned LANES = 3;
  localparam int unsigned OPEN_DEPTH = 3;

  // Segment codes within one knot's run of segments.
  localparam int unsigned SEG_W = 2;
  localparam logic [SEG_W-1:0] SEG_FIRST = 2'd0;
  localparam logic [SEG_W-1:0] SEG_WRAP_LAST = 2'd3;

  // Knot count code at which the opening knots are complete.
  localparam logic [1:0] SEEN_FULL = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             knot_we;    // Accept beat: shift the knot into the recent history.
    logic             open_we;    // Also store it as one of the opening knots.
    logic [SEG_W-1:0] open_idx;   // Slot of the opening knot to write.
    logic             win_load;   // Load the blend window for the first segment.
    logic             issue;      // Send one point into the blend pipeline.
    logic             pt_last;    // The issued point is the last one of this knot.
    logic             win_shift;  // Advance the window to the next wrap-around segment.
    logic [SEG_W-1:0] fill_idx;   // Opening knot that enters the window on a shift.
  } cbt_cmd_t;

  // Width of the common denominator 6*P^3, which also bounds every weight.
  function automatic int den_bits(input int p);
    return $clog2(6 * p * p * p + 1);
  endfunction

endpackage

`default_nettype wire

### design/cbt_ctrl.sv
// Controller of the tessellator: tracks the loop's knot count and sequences points and segments.
// Depends on cbt_pkg for the command struct and the segment codes.
`default_nettype none

module cbt_ctrl
  import cbt_pkg::*;
#(
  parameter int POINTS_PER_SEGMENT = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  closes_loop_i,
  input  wire logic                                  adv_i,
  output cbt_cmd_t                                   cmd_o,
  output logic [$clog2(POINTS_PER_SEGMENT)-1:0]      pt_o
);

  localparam int PT_W = $clog2(POINTS_PER_SEGMENT);
  localparam logic [PT_W-1:0] PT_LAST = PT_W'(POINTS_PER_SEGMENT - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } ctrl_state_e;

  ctrl_state_e      state_q, state_d;
  logic [PT_W-1:0]  pt_q, pt_d;
  logic [SEG_W-1:0] seg_q, seg_d;
  logic [1:0]       seen_q, seen_d;
  logic             closing_q, closing_d;

  logic idle;
  logic accept;
  logic issue;
  logic pt_end;
  logic seg_end;

  // Handshake and sequencing conditions.
  assign idle    = (state_q == S_IDLE);
  assign accept  = in_valid_i && idle;
  assign issue   = !idle && adv_i;
  assign pt_end  = (pt_q == PT_LAST);
  assign seg_end = (seg_q == (closing_q ? SEG_WRAP_LAST : SEG_FIRST));

  assign in_stall_o = !idle;
  assign pt_o       = pt_q;

  // Commands to the datapath.
  always_comb begin
    cmd_o.knot_we   = accept;
    cmd_o.open_we   = accept && (seen_q != SEEN_FULL);
    cmd_o.open_idx  = seen_q;
    cmd_o.win_load  = accept && (seen_q == SEEN_FULL);
    cmd_o.issue     = issue;
    cmd_o.pt_last   = issue && pt_end && seg_end;
    cmd_o.win_shift = issue && pt_end && !seg_end;
    cmd_o.fill_idx  = seg_q;
  end

  // Next state: count opening knots, then walk points and segments of one knot.
  always_comb begin
    state_d   = state_q;
    pt_d      = pt_q;
    seg_d     = seg_q;
    seen_d    = seen_q;
    closing_d = closing_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (seen_q == SEEN_FULL) begin
            state_d   = S_EMIT;
            closing_d = closes_loop_i;
            pt_d      = '0;
            seg_d     = SEG_FIRST;
          end else if (closes_loop_i) begin
            // A loop closed before it had four knots is dropped.
            seen_d = '0;
          end else begin
            seen_d = seen_q + 2'd1;
          end
        end
      end
      S_EMIT: begin
        if (issue) begin
          if (pt_end) begin
            pt_d = '0;
            if (seg_end) begin
              state_d = S_IDLE;
              if (closing_q) begin
                seen_d = '0;
              end
            end else begin
              seg_d = seg_q + SEG_W'(1);
            end
          end else begin
            pt_d = pt_q + PT_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pt_q      <= '0;
      seg_q     <= SEG_FIRST;
      seen_q    <= '0;
      closing_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pt_q      <= pt_d;
      seg_q     <= seg_d;
      seen_q    <= seen_d;
      closing_q <= closing_d;
    end
  end

endmodule

`default_nettype wire

### design/cbt_lane.sv
// One coordinate lane of the blend pipeline: weighted sum of four knots and rounding division.
// Depends on cbt_pkg for the tap count and the denominator width.
`default_nettype none

module cbt_lane
  import cbt_pkg::*;
#(
  parameter int POINTS_PER_SEGMENT = 8,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                                   clk_i,
  input  wire logic                                                   adv_i,
  input  wire logic [TAPS-1:0][den_bits(POINTS_PER_SEGMENT)-1:0]      w_i,
  input  wire logic [TAPS-1:0][COORD_BITS-1:0]                        v_i,
  output logic [COORD_BITS-1:0]                                       point_o
);

  localparam int C      = COORD_BITS;
  localparam int WGT_W  = den_bits(POINTS_PER_SEGMENT);
  localparam int P3     = POINTS_PER_SEGMENT * POINTS_PER_SEGMENT * POINTS_PER_SEGMENT;
  localparam int DEN    = 6 * P3;
  localparam int PROD_W = C + WGT_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int NUM_W  = C + WGT_W;
  localparam int SHIFT  = WGT_W - 1;
  localparam int K      = C + 4;
  localparam int EST_W  = C + K + 2;

  // Offset 3P^3 rounds to nearest; DEN*2^(C-1) makes the numerator non-negative.
  localparam longint OFFSET_L = longint'(3 * P3) + longint'(DEN) * (longint'(1) << (C - 1));
  localparam logic [SUM_W-1:0] OFFSET = SUM_W'(OFFSET_L);

  // Reciprocal of the denominator, scaled so the top numerator bits give the quotient
  // to within two.
  localparam longint RECIP_L = (longint'(1) << (K + SHIFT)) / longint'(DEN);
  localparam logic [K:0] RECIP = (K + 1)'(RECIP_L);

  localparam logic [NUM_W-1:0] DEN_N  = NUM_W'(DEN);
  localparam logic [NUM_W-1:0] DEN2_N = NUM_W'(2 * DEN);

  logic signed [PROD_W-1:0] prod_q [TAPS];
  logic [SUM_W-1:0]         sum_d;
  logic [SUM_W-1:0]         num_full;
  logic [NUM_W-1:0]         num_q, num2_q, num3_q;
  logic [C:0]               nt;
  logic [EST_W-1:0]         est_full;
  logic [C-1:0]             est_q, est2_q;
  logic [NUM_W-1:0]         ed_q;
  logic [NUM_W-1:0]         rem;
  logic [1:0]               corr;
  logic [C-1:0]             quo;
  logic [C-1:0]             point_q;

  // Stage 2: four weight-by-coordinate products.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < TAPS; k++) begin
        prod_q[k] <= $signed({1'b0, w_i[k]}) * $signed(v_i[k]);
      end
    end
  end

  // Stage 3: sum of products plus the rounding and bias offset.
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum_d = sum_d + {{(SUM_W - PROD_W){prod_q[k][PROD_W-1]}}, prod_q[k]};
    end
    num_full = sum_d + OFFSET;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      num_q <= num_full[NUM_W-1:0];
    end
  end

  // Stage 4: quotient estimate from the upper numerator bits.
  assign nt       = num_q[NUM_W-1:SHIFT];
  assign est_full = EST_W'(nt) * EST_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      est_q  <= est_full[K +: C];
      num2_q <= num_q;
    end
  end

  // Stage 5: product of the estimate and the denominator.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ed_q   <= NUM_W'(est_q) * DEN_N;
      est2_q <= est_q;
      num3_q <= num2_q;
    end
  end

  // Stage 6: correct the estimate by the remainder and remove the bias.
  always_comb begin
    rem = num3_q - ed_q;
    if (rem >= DEN2_N) begin
      corr = 2'd2;
    end else if (rem >= DEN_N) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
    quo = est2_q + C'(corr);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      point_q <= {~quo[C-1], quo[C-2:0]};
    end
  end

  assign point_o = point_q;

endmodule

`default_nettype wire

### design/cbt_datapath.sv
// Datapath of the tessellator: knot history, opening knots, blend window, weight table,
// and the pipeline valid chain around three coordinate lanes. Depends on cbt_pkg and cbt_lane.
`default_nettype none

module cbt_datapath
  import cbt_pkg::*;
#(
  parameter int POINTS_PER_SEGMENT = 8,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic signed [COORD_BITS-1:0]            knot_x_i,
  input  wire logic signed [COORD_BITS-1:0]            knot_y_i,
  input  wire logic signed [COORD_BITS-1:0]            knot_z_i,
  input  cbt_cmd_t                                     cmd_i,
  input  wire logic [$clog2(POINTS_PER_SEGMENT)-1:0]   pt_i,
  input  wire logic                                    out_stall_i,
  output logic                                         adv_o,
  output logic                                         out_valid_o,
  output logic signed [COORD_BITS-1:0]                 point_x_o,
  output logic signed [COORD_BITS-1:0]                 point_y_o,
  output logic signed [COORD_BITS-1:0]                 point_z_o,
  output logic                                         run_end_o
);

  localparam int C     = COORD_BITS;
  localparam int P     = POINTS_PER_SEGMENT;
  localparam int WGT_W = den_bits(POINTS_PER_SEGMENT);
  localparam int PIPE  = 6;

  typedef logic [LANES-1:0][C-1:0] knot_t;

  knot_t                       knot_in;
  knot_t                       recent_q [OPEN_DEPTH];
  knot_t                       open_q   [OPEN_DEPTH];
  knot_t                       win_q    [TAPS];
  knot_t                       tap_q    [TAPS];
  logic [TAPS-1:0][WGT_W-1:0]  wtbl     [P];
  logic [TAPS-1:0][WGT_W-1:0]  wt_q;
  logic [TAPS-1:0][C-1:0]      lane_v   [LANES];
  logic [C-1:0]                lane_pt  [LANES];
  logic [PIPE-1:0]             vld_q;
  logic [PIPE-1:0]             last_q;
  logic                        adv;

  // Uniform cubic B-spline weights over the common denominator 6*P^3.
  function automatic int weight(input int k, input int i);
    int j;
    j = P - i;
    case (k)
      0:       return j * j * j;
      1:       return 3 * i * i * i - 6 * i * i * P + 4 * P * P * P;
      2:       return -3 * i * i * i + 3 * i * i * P + 3 * i * P * P + P * P * P;
      default: return i * i * i;
    endcase
  endfunction

  // Constant weight table, one row per point of a segment.
  for (genvar gi = 0; gi < P; gi++) begin : g_wrow
    for (genvar gk = 0; gk < TAPS; gk++) begin : g_wtap
      assign wtbl[gi][gk] = WGT_W'(weight(gk, gi));
    end
  end

  assign knot_in = {knot_z_i, knot_y_i, knot_x_i};

  // Knot storage: recent history, opening knots, and the four-knot blend window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < OPEN_DEPTH; n++) begin
        recent_q[n] <= '0;
        open_q[n]   <= '0;
      end
    end else if (cmd_i.knot_we) begin
      recent_q[0] <= recent_q[1];
      recent_q[1] <= recent_q[2];
      recent_q[2] <= knot_in;
      if (cmd_i.open_we) begin
        open_q[cmd_i.open_idx] <= knot_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_load) begin
      win_q[0] <= recent_q[0];
      win_q[1] <= recent_q[1];
      win_q[2] <= recent_q[2];
      win_q[3] <= knot_in;
    end else if (cmd_i.win_shift) begin
      // Wrap-around segments pull the opening knots in behind the closing knot.
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= open_q[cmd_i.fill_idx];
    end
  end

  // The whole pipeline moves unless a finished point waits at a stalled output.
  assign adv   = !vld_q[PIPE-1] || !out_stall_i;
  assign adv_o = adv;

  // Stage 1: capture the window and the weights of the issued point.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      wt_q <= wtbl[pt_i];
      for (int t = 0; t < TAPS; t++) begin
        tap_q[t] <= win_q[t];
      end
    end
  end

  // Valid and last-point flags travel with the data through all stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE-2:0], cmd_i.issue};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      last_q <= {last_q[PIPE-2:0], cmd_i.pt_last};
    end
  end

  // Regroup taps by coordinate for the lanes.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      for (int t = 0; t < TAPS; t++) begin
        lane_v[l][t] = tap_q[t][l];
      end
    end
  end

  for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
    cbt_lane #(
      .POINTS_PER_SEGMENT (POINTS_PER_SEGMENT),
      .COORD_BITS         (COORD_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .adv_i   (adv),
      .w_i     (wt_q),
      .v_i     (lane_v[gl]),
      .point_o (lane_pt[gl])
    );
  end

  assign out_valid_o = vld_q[PIPE-1];
  assign run_end_o   = last_q[PIPE-1];
  assign point_x_o   = lane_pt[0];
  assign point_y_o   = lane_pt[1];
  assign point_z_o   = lane_pt[2];

endmodule

`default_nettype wire

### design/closed_cubic_bspline_tessellator_unit.sv
// Top level of the closed-loop uniform cubic B-spline tessellator.
// Depends on cbt_pkg, cbt_ctrl and cbt_datapath.
//
// Usage: control knots of a closed 3-D loop arrive one per beat on the input channel
// (in_valid_i / in_stall_o), with closes_loop_i set on the loop's last knot. Points leave
// one per beat on the output channel (out_valid_o / out_stall_i), POINTS_PER_SEGMENT per
// segment, with run_end_o set on the last point caused by a knot.
// Throughput: the first three knots of a loop are taken without a stall and emit nothing.
// Every later knot holds the input until its POINTS_PER_SEGMENT points are issued, and
// the closing knot until its 4*POINTS_PER_SEGMENT points are issued; the controller issues
// one point per cycle, except in an output stall, into the single six-stage blend pipeline.
// The first point of a knot is issued from the emit state and passes the six blend stages.
// A loop closed with fewer than four knots emits nothing and is discarded.
// Reset clears the knot count, the knot history and the pipeline valid bits.
// While the receiver stalls a waiting point, the whole blend pipeline holds, the output
// stays unchanged, and issue of further points pauses; the next knot is taken as soon as
// the last point of the current one has entered the pipeline.
`default_nettype none

module closed_cubic_bspline_tessellator_unit
  import cbt_pkg::*;
#(
  parameter int POINTS_PER_SEGMENT = 8,
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COORD_BITS-1:0]  knot_x_i,
  input  wire logic signed [COORD_BITS-1:0]  knot_y_i,
  input  wire logic signed [COORD_BITS-1:0]  knot_z_i,
  input  wire logic                          closes_loop_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [COORD_BITS-1:0]       point_x_o,
  output logic signed [COORD_BITS-1:0]       point_y_o,
  output logic signed [COORD_BITS-1:0]       point_z_o,
  output logic                               run_end_o
);

  localparam int PT_W = $clog2(POINTS_PER_SEGMENT);

  cbt_cmd_t        cmd;
  logic [PT_W-1:0] pt;
  logic            adv;

  cbt_ctrl #(
    .POINTS_PER_SEGMENT (POINTS_PER_SEGMENT)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .closes_loop_i (closes_loop_i),
    .adv_i         (adv),
    .cmd_o         (cmd),
    .pt_o          (pt)
  );

  cbt_datapath #(
    .POINTS_PER_SEGMENT (POINTS_PER_SEGMENT),
    .COORD_BITS         (COORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .knot_x_i    (knot_x_i),
    .knot_y_i    (knot_y_i),
    .knot_z_i    (knot_z_i),
    .cmd_i       (cmd),
    .pt_i        (pt),
    .out_stall_i (out_stall_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .point_z_o   (point_z_o),
    .run_end_o   (run_end_o)
  );

endmodule

`default_nettype wire

### design/cbt_checker.sv
// Port-level checks of the tessellator's handshake timing, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module cbt_checker #(
  parameter int POINTS_PER_SEGMENT = 8,
  parameter int COORD_BITS = 16
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic signed [COORD_BITS-1:0]  point_x_o,
  input wire logic signed [COORD_BITS-1:0]  point_y_o,
  input wire logic signed [COORD_BITS-1:0]  point_z_o,
  input wire logic                          run_end_o
);

  // A stalled output beat stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(point_x_o) &&
    $stable(point_y_o) && $stable(point_z_o) && $stable(run_end_o))
    else $error("Stalled output beat changed.");

  // The input only starts stalling right after a knot beat was taken.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("Input stall rose without an accepted knot.");

  // A knot that emits points holds the input for at least one full segment.
  a_stall_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> ##(POINTS_PER_SEGMENT - 1) in_stall_o)
    else $error("Input stall shorter than one segment.");

  // The last point is issued only while the pipeline moves.
  a_release_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> $past(!out_valid_o || !out_stall_i))
    else $error("Input stall released while the pipeline was frozen.");

endmodule

bind closed_cubic_bspline_tessellator_unit cbt_checker #(
  .POINTS_PER_SEGMENT (POINTS_PER_SEGMENT),
  .COORD_BITS         (COORD_BITS)
) u_cbt_checker (.*);

`default_nettype wire
